FILE: rtl/tpcr_pkg.sv
`default_nettype none
package tpcr_pkg;
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FWD  = 2'd1;
  localparam logic [1:0] ACT_INV  = 2'd2;
  localparam logic [2:0] REG_RPX = 3'd0;
  localparam logic [2:0] REG_RPY = 3'd1;
  localparam logic [2:0] REG_RPZ = 3'd2;
  localparam logic [2:0] REG_VPX = 3'd3;
  localparam logic [2:0] REG_VPY = 3'd4;
  localparam logic [2:0] REG_VPZ = 3'd5;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  // Coordinates and pivots share this scale, so no datapath depends on it.
  localparam int COORD_FRAC_BITS = 16;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tilt_plane_coordinate_rotator_top.sv
`default_nettype none
// Channel | Dir | Payload
// s_axis  | in  | tuser: action[1:0]; tdata: in_x[31:0], in_y[63:32], in_z[95:64]
// m_axis  | out | tuser: status[0];   tdata: out_x[31:0], out_y[63:32], out_z[95:64]
// cfg     | in  | cfg_we, cfg_index[2:0], cfg_data[31:0]
// A transform steps nine products through one shared 32x32 multiplier with a registered
// product, then moves the rows into the output register.
// A load handles three vectors, each with 0 to 30 scaling shifts, 3 squares on the
// multiplier, a 32-step square root and three 62-step divisions on one divider.
// A rejected load or an unused action goes from idle straight to the output state.
// rst is synchronous and restores the identity matrix and zero pivots.
// s_axis_tready is high only in idle; a finished item waits before the output register
// while an earlier result is still held there.
module tilt_plane_coordinate_rotator_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // in_x, in_y, in_z
  input  wire logic [1:0]   s_axis_tuser,  // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // out_x, out_y, out_z
  output logic [0:0]        m_axis_tuser,  // status
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import tpcr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_NORM = 8'b0000_0100,
    S_SQ   = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_WAIT = 8'b1000_0000
  } state_t;

  state_t st;
  logic signed [31:0] rot [9];
  logic signed [31:0] piv [6];
  logic        status;
  logic signed [31:0] d [3];
  logic signed [31:0] addv [3];
  logic signed [31:0] res [3];
  logic [1:0]  ri, cj;
  logic signed [65:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] ma, mb;
  logic        mvalid;
  // load path
  logic signed [32:0] va [3][3];     // three vectors, signed 33-bit components
  logic [31:0] mag [3];
  logic [1:0]  vi, ci;
  logic [63:0] sum;
  logic [31:0] len;
  logic signed [31:0] un [3][3];
  logic        sq_start, dv_start, sq_done, dv_done;
  logic [31:0] root;
  logic [61:0] quo;
  logic        dv_busy;
  logic        fwd;

  tpcr_sqrt u_sqrt (.clk, .rst, .start(sq_start), .val(sum), .done(sq_done), .root);
  tpcr_div  u_div  (.clk, .rst, .start(dv_start), .num({mag[ci], 30'd0} + {31'd0, len[31:1]}),
                    .den(len), .done(dv_done), .quo);

  // shared multiplier operands
  always_comb begin
    ma = '0; mb = '0;
    if (st == S_MUL && ri != 2'd3) begin
      ma = d[cj];
      mb = fwd ? rot[{2'b0, ri} * 4'd3 + {2'b0, cj}] : rot[{2'b0, cj} * 4'd3 + {2'b0, ri}];
    end else begin
      ma = mag[cj];
      mb = mag[cj];
    end
  end

  logic [31:0] absa [3];
  logic [31:0] top;
  always_comb begin
    for (int k = 0; k < 3; k++)
      absa[k] = va[vi][k][32] ? 32'(-va[vi][k]) : va[vi][k][31:0];
    top = mag[0] | mag[1] | mag[2];
  end

  assign s_axis_tready = (st == S_IDLE);
  assign sq_start = (st == S_SQ) && mvalid && cj == 2'd0 && ri == 2'd3;
  assign dv_start = (st == S_DIV) && !dv_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < 9; k++) rot[k] <= (k % 4 == 0) ? ONE_Q30 : '0;
      for (int k = 0; k < 6; k++) piv[k] <= '0;
      mvalid <= 1'b0;
      dv_busy <= 1'b0;
    end else begin
      if (cfg_we && cfg_index <= REG_VPZ) piv[cfg_index] <= cfg_data;
      // load the output register from S_OUT, hold it until taken
      m_axis_tvalid <= ((st == S_OUT) && (!m_axis_tvalid || m_axis_tready)) ||
                       (m_axis_tvalid && !m_axis_tready);
      prod <= ma * mb;
      unique case (st)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          ri <= '0; cj <= '0; acc <= '0; mvalid <= 1'b0;
          for (int k = 0; k < 3; k++) res[k] <= '0;
          status <= 1'b0;
          fwd <= (s_axis_tuser == ACT_FWD);
          for (int k = 0; k < 3; k++) begin
            d[k] <= sat32(34'(signed'(s_axis_tdata[32*k +: 32])) -
                          34'(piv[3'((s_axis_tuser == ACT_FWD) ? k + 3 : k)]));
            addv[k] <= piv[3'((s_axis_tuser == ACT_FWD) ? k : k + 3)];
          end
          for (int k = 0; k < 3; k++) begin
            va[0][k] <= 33'(signed'(s_axis_tdata[32*k +: 32]));
          end
          va[1][0] <= 33'(signed'(s_axis_tdata[95:64]));
          va[1][1] <= '0;
          va[1][2] <= -33'(signed'(s_axis_tdata[31:0]));
          va[2][0] <= '0;
          va[2][1] <= 33'(signed'(s_axis_tdata[95:64]));
          va[2][2] <= -33'(signed'(s_axis_tdata[63:32]));
          vi <= '0;
          if (s_axis_tuser == ACT_FWD || s_axis_tuser == ACT_INV) st <= S_MUL;
          else if (s_axis_tuser == ACT_LOAD) begin
            if (signed'(s_axis_tdata[95:64]) <= 0) begin
              status <= 1'b1;
              st <= S_OUT;
            end else st <= S_NORM;
          end else st <= S_OUT;
        end
        S_MUL: begin
          // product for (ri,cj) is registered into prod and lands there on the next cycle
          mvalid <= 1'b1;
          if (cj == 2'd2) begin
            cj <= '0; ri <= ri + 2'd1;
          end else cj <= cj + 2'd1;
          if (mvalid && cj == 2'd0 && ri != 2'd0) begin
            // acc+prod completes row ri-1 here
            res[ri - 2'd1] <= sat32(34'((acc + 66'(prod) + 66'sd536870912) >>> 30) +
                                    34'(addv[ri - 2'd1]));
            acc <= '0;
            if (ri == 2'd3) st <= S_OUT;
          end else if (mvalid) acc <= acc + 66'(prod);
        end
        S_NORM: begin
          if (mvalid) begin
            // scale up until the largest magnitude reaches 2^30
            if (top == 32'd0) begin
              for (int k = 0; k < 3; k++) un[vi][k] <= '0;
              st <= S_WAIT;
            end else if (!(mag[0] >= 32'h4000_0000 || mag[1] >= 32'h4000_0000 ||
                           mag[2] >= 32'h4000_0000)) begin
              for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
            end else begin
              st <= S_SQ; cj <= '0; ri <= '0; sum <= '0; mvalid <= 1'b0;
            end
          end else begin
            for (int k = 0; k < 3; k++) mag[k] <= absa[k];
            mvalid <= 1'b1;
          end
        end
        S_SQ: begin
          mvalid <= 1'b1;
          if (ri != 2'd3) begin
            if (cj == 2'd2) ri <= 2'd3; else cj <= cj + 2'd1;
            if (mvalid) sum <= sum + 64'(prod);
          end else begin
            if (cj != 2'd0) begin
              sum <= sum + 64'(prod); cj <= '0;
            end else st <= S_SQRT;
          end
        end
        S_SQRT: if (sq_done) begin
          len <= root; ci <= '0; st <= S_DIV;
        end
        S_DIV: begin
          if (!dv_busy) dv_busy <= 1'b1;
          else if (dv_done) begin
            dv_busy <= 1'b0;
            un[vi][ci] <= va[vi][ci][32] ? -32'(quo) : 32'(quo);
            if (ci == 2'd2) st <= S_WAIT; else ci <= ci + 2'd1;
          end
        end
        S_WAIT: begin
          mvalid <= 1'b0;
          if (vi == 2'd2) begin
            for (int k = 0; k < 3; k++) begin
              rot[3*k + 0] <= un[1][k];
              rot[3*k + 1] <= un[2][k];
              rot[3*k + 2] <= un[0][k];
            end
            st <= S_OUT;
          end else begin
            vi <= vi + 2'd1; st <= S_NORM;
          end
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {res[2], res[1], res[0]};
          m_axis_tuser <= status;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tpcr_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: q = num / den, 62-bit num, 32-bit den.
module tpcr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [61:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [61:0]      quo
);
  logic [32:0] rem;
  logic [61:0] q;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [33:0] sh;

  assign sh    = {rem, q[61]};
  assign trial = sh[32:0] - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        q    <= num;
        d    <= den;
        cnt  <= 6'd61;
      end else if (busy) begin
        if (sh[33] || sh[32:0] >= {1'b0, d}) begin
          rem <= sh[33] ? (sh[32:0] - {1'b0, d}) : trial;
          q   <= {q[60:0], 1'b1};
        end else begin
          rem <= sh[32:0];
          q   <= {q[60:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tpcr_sqrt.sv
`default_nettype none
// Bit-pair integer square root, one result bit per cycle over a 64-bit operand.
module tpcr_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] tr;

  assign tr   = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= val;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (n >= tr) begin
          n   <= n - tr;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import tpcr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // in_x[31:0], in_y[63:32], in_z[95:64]
  logic [1:0] s_axis_tuser = '0;    // action[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // out_x[31:0], out_y[63:32], out_z[95:64]
  logic [0:0] m_axis_tuser;         // status[0]
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
    logic status;
  } point_res_t;

  // Plane-rotation predictor: the matrix and pivots mirror the block's state.
  class rotation_scoreboard;
    logic signed [31:0] mat [9];
    logic signed [31:0] pivot [6];
    point_res_t pending_q [$];
    int n_errors;
    int n_checked;
    int n_loads;
    int n_rejects;

    function new();
      for (int i = 0; i < 9; i++) mat[i] = (i % 4 == 0) ? ONE_Q30 : 32'sd0;
      for (int i = 0; i < 6; i++) pivot[i] = '0;
      n_errors = 0;
      n_checked = 0;
      n_loads = 0;
      n_rejects = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      n_errors++;
    endtask

    function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Normalize to unit length in Q2.30.
    function automatic void unit(input longint a [3], output logic signed [31:0] u [3]);
      longint unsigned m [3];
      longint unsigned top;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      top = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = a[i] < 0 ? longint'(-a[i]) : longint'(a[i]);
        if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
        for (int i = 0; i < 3; i++) u[i] = '0;
        return;
      end
      while (top < (64'd1 << 30)) begin
        top <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 30) + (len >> 1)) / len;
        u[i] = a[i] < 0 ? -32'(q) : 32'(q);
      end
    endfunction

    function automatic longint round_q30(longint acc);
      longint v;
      v = acc + (64'sd1 << 29);
      return v >>> 30;  // arithmetic shift equals floor division
    endfunction

    function void note_input(logic [1:0] act, logic [95:0] d);
      longint p [3];
      longint dv [3];
      longint vz [3];
      longint vx [3];
      longint vy [3];
      logic signed [31:0] uz [3];
      logic signed [31:0] ux [3];
      logic signed [31:0] uy [3];
      longint acc;
      int sub;
      int add;
      longint o [3];
      point_res_t r;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'($signed(d[32*i +: 32]));
        o[i] = 0;
      end
      r.status = 1'b0;
      if (act == ACT_LOAD) begin
        n_loads++;
        if (p[2] <= 0) begin
          r.status = 1'b1;
          n_rejects++;
        end else begin
          vz = '{p[0], p[1], p[2]};
          vx = '{p[2], 0, -p[0]};
          vy = '{0, p[2], -p[1]};
          unit(vz, uz);
          unit(vx, ux);
          unit(vy, uy);
          for (int i = 0; i < 3; i++) begin
            mat[3*i] = ux[i];
            mat[3*i+1] = uy[i];
            mat[3*i+2] = uz[i];
          end
        end
      end else if (act == ACT_FWD || act == ACT_INV) begin
        sub = (act == ACT_FWD) ? 3 : 0;
        add = (act == ACT_FWD) ? 0 : 3;
        for (int i = 0; i < 3; i++) dv[i] = clamp32(p[i] - longint'(pivot[sub+i]));
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++)
            acc += dv[j] * longint'((act == ACT_FWD) ? mat[3*i+j] : mat[3*j+i]);
          o[i] = clamp32(round_q30(acc) + longint'(pivot[add+i]));
        end
      end
      r.x = o[0][31:0];
      r.y = o[1][31:0];
      r.z = o[2][31:0];
      pending_q.push_back(r);
    endfunction

    task check_result(logic [95:0] d, logic st);
      point_res_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (d[31:0] !== e.x)
        report_mismatch($sformatf("out_x %h, predicted %h", d[31:0], e.x));
      if (d[63:32] !== e.y)
        report_mismatch($sformatf("out_y %h, predicted %h", d[63:32], e.y));
      if (d[95:64] !== e.z)
        report_mismatch($sformatf("out_z %h, predicted %h", d[95:64], e.z));
      if (st !== e.status)
        report_mismatch($sformatf("status %b, predicted %b", st, e.status));
    endtask
  endclass

  rotation_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  int n_sent = 0;
  localparam int WATCHDOG_LIMIT = 20000;

  tilt_plane_coordinate_rotator_top u_dut (.*);

  always #5 clk = ~clk;

  // Receiver: stall at random, or hold off entirely when asked.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", sb.pending_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offer one item, idling first at random; return after acceptance.
  task automatic send_item(logic [1:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {z, y, x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(act, {z, y, x});
    n_sent++;
  endtask

  // Drain outstanding results, then idle a while before any write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_VPZ) sb.pivot[idx] = $signed(val);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom;
      default: return 32'($signed($urandom_range(400 << 16)) - (200 << 16));
    endcase
  endfunction

  // Mostly transforms, with plane loads (mostly valid normals) and a few unused actions.
  task automatic send_random();
    int k;
    logic [31:0] z;
    k = $urandom_range(99);
    if (k < 15) begin
      z = ($urandom_range(9) == 0) ? rand_coord() : $urandom_range(32'h0020_0000, 1);
      send_item(ACT_LOAD, 32'($signed($urandom_range(1 << 17)) - (1 << 16)),
                32'($signed($urandom_range(1 << 17)) - (1 << 16)), z);
    end else if (k < 18) begin
      send_item(ACT_LOAD, rand_coord(), rand_coord(), rand_coord());
    end else if (k < 20) begin
      send_item(2'd3, rand_coord(), rand_coord(), rand_coord());
    end else begin
      send_item((k < 60) ? ACT_FWD : ACT_INV, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic random_pivots(bit extreme);
    for (int i = 0; i <= 5; i++)
      write_reg(3'(i), extreme ? (($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000)
                               : 32'($signed($urandom_range(100 << 16)) - (50 << 16)));
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity transforms, extremes, loads incl. rejects and degenerate normals.
    send_item(ACT_FWD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_item(ACT_INV, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 32'h0, 32'h0, 32'h0);
    send_item(ACT_LOAD, 32'h1, 32'h1, 32'h8000_0000);
    send_item(ACT_LOAD, 32'h0, 32'h0, 32'h1);
    send_item(ACT_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_FWD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_INV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_LOAD, 32'h0000_0A00, 32'hFFFF_F600, 32'h0001_0000);
    send_item(ACT_FWD, 32'h0064_0000, 32'hFF9C_0000, 32'h0000_8000);
    send_item(ACT_INV, 32'h0064_0000, 32'hFF9C_0000, 32'h0000_8000);
    drain();
    random_pivots(1'b1);
    write_reg(3'd7, 32'h1234_5678);  // out of range index, ignored
    send_item(ACT_FWD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_item(ACT_INV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);

    // Random phases: none, sender idle, receiver stall, both; new pivots each phase.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      random_pivots(ph == 5);
      send_idle_pct = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 19 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 19 : 0;
      if (ph == 2) fork
        begin
          hold_off <= 1'b1;
          repeat (300) @(posedge clk);
          hold_off <= 1'b0;
        end
      join_none
      repeat (80) send_random();
    end

    drain();
    for (int i = 0; i <= 5; i++) write_reg(3'(i), 32'h0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) send_random();
    drain();

    $display("Checked %0d results from %0d items; %0d plane loads, %0d rejected.",
             sb.n_checked, n_sent, sb.n_loads, sb.n_rejects);
    $display("Covered transforms both ways, pivot extremes and all idling phases.");
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
